// ===== hw/rtl/tca_pkg.sv =====
// tca_pkg: shared types and constants for the triangle classifier
// no dependencies
package tca_pkg;

  localparam int unsigned AreaBits = 25;

  typedef enum logic [1:0] {
    SideScalene     = 2'd0,
    SideIsosceles   = 2'd1,
    SideEquilateral = 2'd2
  } side_kind_e;

  typedef enum logic [1:0] {
    AngleRight  = 2'd0,
    AngleAcute  = 2'd1,
    AngleObtuse = 2'd2
  } angle_kind_e;

endpackage

// ===== hw/rtl/tca_if.sv =====
// tca_if: valid/ready channel carrying one word of triangle data
// depends on nothing; payload width is a parameter
interface tca_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tca_front.sv =====
// tca_front: sort, triangle test, side and angle kind, heron product
// depends on tca_pkg
module tca_front #(
  parameter int unsigned SideBits = 12,
  parameter int unsigned ProdBits = 4 * (SideBits + 2)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [SideBits-1:0] side_a_i,
  input  logic [SideBits-1:0] side_b_i,
  input  logic [SideBits-1:0] side_c_i,
  output logic                valid_o,
  output logic                tri_o,
  output logic [1:0]          kind_o,
  output logic [1:0]          angle_o,
  output logic [ProdBits-1:0] prod_o
);
  import tca_pkg::*;

  localparam int unsigned SumBits = SideBits + 2;
  localparam int unsigned SqBits  = 2 * SideBits + 1;
  localparam int unsigned HalfBits = 2 * SumBits;

  // stage 1: sort and classify
  logic [SideBits-1:0] big_d, mid_d, sml_d, t0, t1;
  logic [SideBits-1:0] big_q, mid_q, sml_q;
  logic                v1_q, tri_d, tri1_q;
  logic [1:0]          kind_d, kind1_q;

  always_comb begin
    big_d = side_a_i;
    mid_d = side_b_i;
    sml_d = side_c_i;
    if (mid_d > big_d) begin
      t0 = big_d; big_d = mid_d; mid_d = t0;
    end else begin
      t0 = '0;
    end
    if (sml_d > mid_d) begin
      t1 = mid_d; mid_d = sml_d; sml_d = t1;
    end else begin
      t1 = '0;
    end
    if (mid_d > big_d) begin
      t0 = big_d; big_d = mid_d; mid_d = t0;
    end
    tri_d = ({1'b0, sml_d} + {1'b0, mid_d}) > {1'b0, big_d};
    if (side_a_i == side_b_i && side_b_i == side_c_i) kind_d = SideEquilateral;
    else if (side_a_i == side_b_i || side_b_i == side_c_i || side_a_i == side_c_i)
      kind_d = SideIsosceles;
    else kind_d = SideScalene;
  end

  // stage 2: squares and the four heron factors, two pair products
  logic [SqBits-1:0]   lhs_q, rhs_q;
  logic [HalfBits-1:0] p0_q, p1_q;
  logic                v2_q, tri2_q;
  logic [1:0]          kind2_q;
  logic [SumBits-1:0]  f_sum, f_a, f_b, f_c;

  always_comb begin
    f_sum = SumBits'(big_q) + SumBits'(mid_q) + SumBits'(sml_q);
    f_a   = SumBits'(mid_q) + SumBits'(sml_q) - SumBits'(big_q);
    f_b   = SumBits'(big_q) + SumBits'(sml_q) - SumBits'(mid_q);
    f_c   = SumBits'(big_q) + SumBits'(mid_q) - SumBits'(sml_q);
  end

  // stage 3: angle compare and final product
  logic [1:0] angle_d;
  always_comb begin
    if (lhs_q == rhs_q) angle_d = AngleRight;
    else if (lhs_q > rhs_q) angle_d = AngleAcute;
    else angle_d = AngleObtuse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big_q   <= big_d;
      mid_q   <= mid_d;
      sml_q   <= sml_d;
      tri1_q  <= tri_d;
      kind1_q <= kind_d;
      lhs_q   <= SqBits'(sml_q * sml_q) + SqBits'(mid_q * mid_q);
      rhs_q   <= SqBits'(big_q * big_q);
      p0_q    <= f_sum * f_a;
      p1_q    <= f_b * f_c;
      tri2_q  <= tri1_q;
      kind2_q <= kind1_q;
      tri_o   <= tri2_q;
      kind_o  <= tri2_q ? kind2_q : 2'd0;
      angle_o <= tri2_q ? angle_d : 2'd0;
      prod_o  <= tri2_q ? ProdBits'(p0_q * p1_q) : '0;
    end
  end

endmodule

// ===== hw/rtl/tca_sqrt.sv =====
// tca_sqrt: pipelined integer square root, one result bit per stage
// depends on tca_pkg
module tca_sqrt #(
  parameter int unsigned InBits  = 56,
  parameter int unsigned OutBits = InBits / 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [4:0]         tag_i,
  input  logic [InBits-1:0]  rad_i,
  output logic               valid_o,
  output logic [4:0]         tag_o,
  output logic [OutBits-1:0] root_o
);
  import tca_pkg::*;

  localparam int unsigned RemBits = OutBits + 2;

  logic [OutBits:0]           v_q;
  logic [OutBits:0][4:0]      tag_q;
  logic [OutBits:0][InBits-1:0]  rad_q;
  logic [OutBits:0][OutBits-1:0] root_q;
  logic [OutBits:0][RemBits-1:0] rem_q;

  assign v_q[0]    = valid_i;
  assign tag_q[0]  = tag_i;
  assign rad_q[0]  = rad_i;
  assign root_q[0] = '0;
  assign rem_q[0]  = '0;

  for (genvar i = 0; i < OutBits; i++) begin : g_stage
    logic [RemBits-1:0] rem_sh, trial;
    logic               ok;
    always_comb begin
      rem_sh = {rem_q[i][RemBits-3:0], rad_q[i][InBits-1 -: 2]};
      trial  = {root_q[i], 2'b01};
      ok     = rem_sh >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1]  <= tag_q[i];
        rad_q[i+1]  <= rad_q[i] << 2;
        root_q[i+1] <= {root_q[i][OutBits-2:0], ok};
        rem_q[i+1]  <= ok ? rem_sh - trial : rem_sh;
      end
    end
  end

  assign valid_o = v_q[OutBits];
  assign tag_o   = tag_q[OutBits];
  assign root_o  = root_q[OutBits];

endmodule

// ===== hw/rtl/triangle_classify_area.sv =====
// triangle_classify_area: top level, front stages, root pipeline, output skid
// throughput: one triangle per cycle unless a held output word is not taken
// the root pipeline (one bit per stage) sets the depth; stall freezes all stages
// reset clears valid bits only; data registers carry no reset
// depends on tca_pkg, tca_if, tca_front, tca_sqrt
module triangle_classify_area #(
  parameter int unsigned SIDE_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  tca_if.sink   in_i,
  tca_if.source out_o
);
  import tca_pkg::*;

  localparam int unsigned ProdBits = 4 * (SIDE_BITS + 2);
  localparam int unsigned RootBits = ProdBits / 2;

  logic                en;
  logic                f_valid, f_tri;
  logic [1:0]          f_kind, f_angle;
  logic [ProdBits-1:0] f_prod;
  logic                s_valid;
  logic [4:0]          s_tag;
  logic [RootBits-1:0] s_root;
  logic [AreaBits-1:0] area;
  logic                out_v_q;
  logic [29:0]         out_q;

  // pipeline advances unless a held word is not taken
  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  tca_front #(.SideBits(SIDE_BITS), .ProdBits(ProdBits)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .side_a_i(in_i.data[SIDE_BITS-1:0]),
    .side_b_i(in_i.data[2*SIDE_BITS-1:SIDE_BITS]),
    .side_c_i(in_i.data[3*SIDE_BITS-1:2*SIDE_BITS]),
    .valid_o(f_valid), .tri_o(f_tri), .kind_o(f_kind), .angle_o(f_angle),
    .prod_o(f_prod)
  );

  tca_sqrt #(.InBits(ProdBits), .OutBits(RootBits)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid),
    .tag_i({f_tri, f_kind, f_angle}), .rad_i(f_prod),
    .valid_o(s_valid), .tag_o(s_tag), .root_o(s_root)
  );

  always_comb begin
    if (RootBits > AreaBits && (s_root >> AreaBits) != '0) area = '1;
    else area = AreaBits'(s_root);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {area, s_tag};
  end

  // word layout: area[29:5], is_triangle[4], side_kind[3:2], angle_kind[1:0]
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("held word changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("stalled with empty output");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data[4] |-> out_o.data[29:5] == '0 && out_o.data[3:0] == 4'd0)
    else $error("non-triangle with nonzero fields");

endmodule
